// File: rtl/gpr_pkg.sv
// Shared types, register codes and field-spreading helpers for the GPIO port register block.
package gpr_pkg;

  localparam int PIN_COUNT_DEF = 16;
  localparam int PORT_PINS     = 16;

  typedef enum logic [3:0] {
    REG_MODE  = 4'd0,
    REG_OTYPE = 4'd1,
    REG_SPEED = 4'd2,
    REG_PULL  = 4'd3,
    REG_IDATA = 4'd4,
    REG_ODATA = 4'd5,
    REG_BSRR  = 4'd6,
    REG_LOCK  = 4'd7,
    REG_AFL   = 4'd8,
    REG_AFH   = 4'd9
  } reg_sel_t;

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } acc_kind_t;

  // lock key sequence progress
  typedef enum logic [1:0] {
    LK_WAIT   = 2'd0,
    LK_FIRST  = 2'd1,
    LK_SECOND = 2'd2
  } lock_phase_t;

  typedef struct packed {
    acc_kind_t   kind;
    reg_sel_t    sel;
    logic [31:0] wdata;
    logic [15:0] levels;
  } gpr_acc_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pin_drive;
    logic        lock_active;
  } gpr_rsp_t;

  // one pin bit -> two field bits
  function automatic logic [31:0] spread2(input logic [15:0] pins);
    logic [31:0] res;
    res = '0;
    for (int i = 0; i < PORT_PINS; i++) begin
      res[2*i +: 2] = {2{pins[i]}};
    end
    return res;
  endfunction

  // one pin bit -> four field bits, eight pins per register
  function automatic logic [31:0] spread4(input logic [7:0] pins);
    logic [31:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      res[4*i +: 4] = {4{pins[i]}};
    end
    return res;
  endfunction

endpackage

// File: rtl/gpr_regs.sv
// GPIO port register file: config registers, output data, lock sequencer and read mux.
module gpr_regs #(
  parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  gpr_pkg::gpr_acc_t acc,
  output gpr_pkg::gpr_rsp_t rsp
);
  import gpr_pkg::*;

  localparam logic [16:0] PRESENT_W = (17'(1) << PIN_COUNT) - 17'(1);
  localparam logic [15:0] PRESENT   = PRESENT_W[15:0];

  logic [31:0] mode_bits, mode_bits_next;
  logic [15:0] otype_bits, otype_bits_next;
  logic [31:0] speed_bits, speed_bits_next;
  logic [31:0] pull_bits, pull_bits_next;
  logic [15:0] odata_bits, odata_bits_next;
  logic [31:0] afl_bits, afl_bits_next;
  logic [31:0] afh_bits, afh_bits_next;
  logic [16:0] lock_bits, lock_bits_next;
  lock_phase_t lock_phase, lock_phase_next;

  logic        wr;
  logic [15:0] locked;
  logic [15:0] free_pins;
  logic        lock_wr;
  logic        key;
  logic [15:0] lk_mask;
  logic        same;
  logic [31:0] rd;

  assign wr        = en && (acc.kind == ACC_WRITE);
  assign locked    = lock_bits[16] ? lock_bits[15:0] : 16'd0;
  assign free_pins = PRESENT & ~locked;
  assign lock_wr   = wr && (acc.sel == REG_LOCK) && !lock_bits[16];
  assign key       = acc.wdata[16];
  assign lk_mask   = acc.wdata[15:0] & PRESENT;
  assign same      = (lk_mask == lock_bits[15:0]);

  // config and data register updates; locked config fields keep their value, output data ignores the lock
  always_comb begin
    logic [31:0] wm2;
    logic [15:0] wm1;
    logic [31:0] wml;
    logic [31:0] wmh;
    wm2 = spread2(free_pins);
    wm1 = free_pins;
    wml = spread4(free_pins[7:0]);
    wmh = spread4(free_pins[15:8]);
    mode_bits_next  = mode_bits;
    otype_bits_next = otype_bits;
    speed_bits_next = speed_bits;
    pull_bits_next  = pull_bits;
    odata_bits_next = odata_bits;
    afl_bits_next   = afl_bits;
    afh_bits_next   = afh_bits;
    if (wr) begin
      case (acc.sel)
        REG_MODE:  mode_bits_next  = (mode_bits & ~wm2) | (acc.wdata & wm2);
        REG_OTYPE: otype_bits_next = (otype_bits & ~wm1) | (acc.wdata[15:0] & wm1);
        REG_SPEED: speed_bits_next = (speed_bits & ~wm2) | (acc.wdata & wm2);
        REG_PULL:  pull_bits_next  = (pull_bits & ~wm2) | (acc.wdata & wm2);
        REG_ODATA: odata_bits_next = acc.wdata[15:0] & PRESENT;
        REG_BSRR:  odata_bits_next = (odata_bits & ~(acc.wdata[31:16] & PRESENT))
                                   | (acc.wdata[15:0] & PRESENT);
        REG_AFL:   afl_bits_next   = (afl_bits & ~wml) | (acc.wdata & wml);
        REG_AFH:   afh_bits_next   = (afh_bits & ~wmh) | (acc.wdata & wmh);
        default: ;
      endcase
    end
  end

  // lock sequencer: next phase
  always_comb begin
    lock_phase_next = lock_phase;
    if (lock_wr) begin
      case (lock_phase)
        LK_FIRST:  lock_phase_next = (!key && same) ? LK_SECOND
                                   : (key ? LK_FIRST : LK_WAIT);
        LK_SECOND: lock_phase_next = (key && same) ? LK_WAIT
                                   : (key ? LK_FIRST : LK_WAIT);
        default:   lock_phase_next = key ? LK_FIRST : LK_WAIT;
      endcase
    end
  end

  // lock sequencer: lock register
  always_comb begin
    lock_bits_next = lock_bits;
    if (lock_wr) begin
      if (lock_phase == LK_SECOND && key && same) begin
        lock_bits_next = {1'b1, lk_mask};
      end else begin
        lock_bits_next = {1'b0, lk_mask};
      end
    end
  end

  // read mux
  always_comb begin
    rd = '0;
    if (acc.kind == ACC_READ) begin
      case (acc.sel)
        REG_MODE:  rd = mode_bits;
        REG_OTYPE: rd = {16'd0, otype_bits};
        REG_SPEED: rd = speed_bits;
        REG_PULL:  rd = pull_bits;
        REG_IDATA: rd = {16'd0, acc.levels & PRESENT};
        REG_ODATA: rd = {16'd0, odata_bits};
        REG_LOCK:  rd = {15'd0, lock_bits};
        REG_AFL:   rd = afl_bits;
        REG_AFH:   rd = afh_bits;
        default:   rd = '0;
      endcase
    end
  end

  assign rsp.read_data   = rd;
  assign rsp.pin_drive   = odata_bits_next;
  assign rsp.lock_active = lock_bits_next[16];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits  <= '0;
      otype_bits <= '0;
      speed_bits <= '0;
      pull_bits  <= '0;
      odata_bits <= '0;
      afl_bits   <= '0;
      afh_bits   <= '0;
      lock_bits  <= '0;
      lock_phase <= LK_WAIT;
    end else begin
      mode_bits  <= mode_bits_next;
      otype_bits <= otype_bits_next;
      speed_bits <= speed_bits_next;
      pull_bits  <= pull_bits_next;
      odata_bits <= odata_bits_next;
      afl_bits   <= afl_bits_next;
      afh_bits   <= afh_bits_next;
      lock_bits  <= lock_bits_next;
      lock_phase <= lock_phase_next;
    end
  end

endmodule

// File: rtl/gpio_port_register_block.sv
// Top level of the GPIO port register block: input stage, register file, result stage.
// Path: input register, then result register; the result is offered from the result
//   register, and a result stage that is not drained holds the access in the input stage;
//   register state changes as the access leaves the input stage.
// Throughput: one access per cycle, limited only by the result stage being drained.
// Reset: rst is synchronous, active high; all port registers, the lock key and the
//   lock sequence clear to zero. Once locked, the lock holds until the next reset.
module gpio_port_register_block #(
  parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // write_data[31:0], pin_levels[47:32]
  input  logic [4:0]  s_axis_tuser,  // mode[0], reg_select[4:1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // read_data[31:0], pin_drive[47:32],
                                     // lock_active[48], zero pad[55:49]
);
  import gpr_pkg::*;

  // input stage
  logic     in_valid;
  gpr_acc_t in_acc;
  logic     s_fire;
  logic     advance;    // access moves from input stage into result stage
  gpr_rsp_t rsp;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_acc.kind   <= acc_kind_t'(s_axis_tuser[0]);
      in_acc.sel    <= reg_sel_t'(s_axis_tuser[4:1]);
      in_acc.wdata  <= s_axis_tdata[31:0];
      in_acc.levels <= s_axis_tdata[47:32];
    end
  end

  // register file; state updates only on advance
  gpr_regs #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regs (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .acc (in_acc),
    .rsp (rsp)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {7'd0, rsp.lock_active, rsp.pin_drive, rsp.read_data};
    end
  end

  // checks
  // an empty result stage never stalls the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result stage");

  // lock, once taken, is only cleared by reset
  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(rsp.lock_active)) |-> rsp.lock_active)
    else $error("lock key dropped without reset");

  // every new result comes from a staged access
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_valid))
    else $error("result produced without a staged access");

endmodule
